FILE: rtl/core/go_back_n_link_controller_unit_macros.svh
// assertion macros shared by the link controller rtl
// no dependencies; included by the modules that check their own logic
`ifndef GO_BACK_N_LINK_CONTROLLER_UNIT_MACROS_SVH
`define GO_BACK_N_LINK_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define GLC_ASSERT_HOLD(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("glc invariant violated");
// same-cycle implication
`define GLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glc implication violated");
// next-cycle implication
`define GLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glc sequence violated");
`else
`define GLC_ASSERT_HOLD(label, clk, rst_n, cond)
`define GLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/glc_pkg.sv
// shared types and constants of the go-back-n link controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package glc_pkg;

    localparam int SEQ_W = 4;
    localparam int LEN_W = 9;

    // event codes on the operation field
    localparam logic [2:0] OP_PACKET_READY = 3'd0;
    localparam logic [2:0] OP_LINE_READY   = 3'd1;
    localparam logic [2:0] OP_FRAME        = 3'd2;
    localparam logic [2:0] OP_DATA_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_ACK_TIMEOUT  = 3'd4;

    // received frame kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    // header plus crc bytes stripped on deliver
    localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 9'd7;
    // saturation of the buffered frame count
    localparam logic [SEQ_W-1:0] COUNT_MAX = 4'd15;
    // commands kept per event ahead of the status
    localparam logic [4:0] MAX_CMDS = 5'd16;

    typedef enum logic [2:0] {
        ACT_SEND_DATA = 3'd0,
        ACT_SEND_ACK  = 3'd1,
        ACT_SEND_NAK  = 3'd2,
        ACT_DELIVER   = 3'd3,
        ACT_STOP_TMR  = 3'd4,
        ACT_STATUS    = 3'd5
    } t_action;

    // event class decided by the front end
    typedef enum logic [3:0] {
        CLS_PACKET,
        CLS_LINE,
        CLS_BAD_FRAME,
        CLS_DATA_FRAME,
        CLS_ACK_FRAME,
        CLS_NAK_FRAME,
        CLS_RESEND,
        CLS_ACK_TIMEOUT,
        CLS_NONE
    } t_cls;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ACKS,
        ST_NAK_STOP,
        ST_RESEND,
        ST_STATUS
    } t_state;

    typedef struct packed {
        t_cls             cls;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] fack;
        logic [LEN_W-1:0] dlen;
    } t_evt;

    typedef struct packed {
        t_action          action;
        logic [SEQ_W-1:0] slot;
        logic             load_slot;
        logic [SEQ_W-1:0] ack_number;
        logic [LEN_W-1:0] delivered_length;
        logic             ack_tmr_start;
        logic             ack_tmr_stop;
        logic             network_enable;
        logic             last;
    } t_item;

    // queue head handed from front to back
    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_queue_head;

endpackage

FILE: rtl/core/glc_front.sv
// front end: accepts link events, classifies them and queues them
// depends on glc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "go_back_n_link_controller_unit_macros.svh"

module glc_front
    import glc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_operation,
    input  logic              i_frame_good,
    input  logic [1:0]        i_frame_kind,
    input  logic [SEQ_W-1:0]  i_frame_seq,
    input  logic [SEQ_W-1:0]  i_frame_ack,
    input  logic [LEN_W-1:0]  i_frame_length,
    output t_queue_head       o_head,
    input  logic              i_pop
);

    t_evt       evt_c;
    logic       push;
    logic [1:0] n_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;

    t_evt       r_mem [2];
    logic [1:0] r_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;

    // classify the event
    always_comb begin
        evt_c.seq  = i_frame_seq;
        evt_c.fack = i_frame_ack;
        evt_c.dlen = (i_frame_length >= FRAME_OVERHEAD) ? i_frame_length - FRAME_OVERHEAD
                                                        : '0;
        priority if (i_operation == OP_PACKET_READY) begin
            evt_c.cls = CLS_PACKET;
        end else if (i_operation == OP_LINE_READY) begin
            evt_c.cls = CLS_LINE;
        end else if (i_operation == OP_FRAME) begin
            priority if (!i_frame_good) begin
                evt_c.cls = CLS_BAD_FRAME;
            end else if (i_frame_kind == KIND_DATA) begin
                evt_c.cls = CLS_DATA_FRAME;
            end else if (i_frame_kind == KIND_NAK) begin
                evt_c.cls = CLS_NAK_FRAME;
            end else begin
                evt_c.cls = CLS_ACK_FRAME;
            end
        end else if (i_operation == OP_DATA_TIMEOUT) begin
            evt_c.cls = CLS_RESEND;
        end else if (i_operation == OP_ACK_TIMEOUT) begin
            evt_c.cls = CLS_ACK_TIMEOUT;
        end else begin
            evt_c.cls = CLS_NONE;
        end
    end

    // two-entry queue control
    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= evt_c;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.evt   = r_mem[r_rd_ptr];

    `GLC_ASSERT_HOLD(a_count_range, i_clk, i_rst_n, r_count <= 2'd2)
    `GLC_ASSERT_HOLD(a_ptr_match, i_clk, i_rst_n, (r_rd_ptr ^ r_wr_ptr) == (r_count == 2'd1))
    `GLC_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != 2'd0)

endmodule

FILE: rtl/core/glc_back.sv
// back end: sequences the commands of one queued event and holds link state
// depends on glc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "go_back_n_link_controller_unit_macros.svh"

module glc_back
    import glc_pkg::*;
#(
    parameter int WINDOW_SIZE = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_item       o_item
);

    localparam int unsigned WinLimit = WINDOW_SIZE;

    t_state           r_state, n_state;
    logic [SEQ_W-1:0] r_nts, n_nts;
    logic [SEQ_W-1:0] r_oldest, n_oldest;
    logic [SEQ_W-1:0] r_exp, n_exp;
    logic [SEQ_W-1:0] r_outstanding, n_outstanding;
    logic             r_line_ready, n_line_ready;
    logic             r_nak_ok, n_nak_ok;
    logic [SEQ_W-1:0] r_rem, n_rem;
    logic [4:0]       r_emitted, n_emitted;
    t_evt             r_evt, n_evt;
    logic             r_out_valid, n_out_valid;
    t_item            r_out, n_out;

    logic             out_free;
    logic             in_win;
    logic [SEQ_W-1:0] ack_o;
    logic             emit_req;
    logic             do_emit;
    t_item            item;

    // circular window test: fack lies in [oldest, nts)
    function automatic logic win_test(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                      logic [SEQ_W-1:0] c);
        logic [SEQ_W-1:0] d_b;
        logic [SEQ_W-1:0] d_c;
        d_b = b - a;
        d_c = c - a;
        return d_b < d_c;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_win   = win_test(r_oldest, r_evt.fack, r_nts);
    assign ack_o    = r_exp + COUNT_MAX;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) n_state = ST_HEAD;
            end
            ST_HEAD: begin
                if (out_free) begin
                    unique case (r_evt.cls)
                        CLS_DATA_FRAME, CLS_ACK_FRAME, CLS_NAK_FRAME: n_state = ST_ACKS;
                        CLS_RESEND:                                   n_state = ST_RESEND;
                        default:                                      n_state = ST_STATUS;
                    endcase
                end
            end
            ST_ACKS: begin
                if (out_free && !in_win) begin
                    n_state = (r_evt.cls == CLS_NAK_FRAME) ? ST_NAK_STOP : ST_STATUS;
                end
            end
            ST_NAK_STOP: begin
                if (out_free) n_state = ST_RESEND;
            end
            ST_RESEND: begin
                if (out_free && (r_rem == '0)) n_state = ST_STATUS;
            end
            ST_STATUS: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command generation and link state updates
    always_comb begin
        n_nts         = r_nts;
        n_oldest      = r_oldest;
        n_exp         = r_exp;
        n_outstanding = r_outstanding;
        n_line_ready  = r_line_ready;
        n_nak_ok      = r_nak_ok;
        n_rem         = r_rem;
        n_evt         = r_evt;
        o_pop         = 1'b0;
        emit_req      = 1'b0;
        item          = '0;
        item.action   = ACT_SEND_DATA;

        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_evt = i_head.evt;
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    unique case (r_evt.cls)
                        CLS_PACKET: begin
                            emit_req        = 1'b1;
                            item.action     = ACT_SEND_DATA;
                            item.slot       = r_nts;
                            item.load_slot  = 1'b1;
                            item.ack_number = ack_o;
                            if (r_outstanding < COUNT_MAX) n_outstanding = r_outstanding + 1'b1;
                            n_line_ready    = 1'b0;
                            n_nts           = r_nts + 1'b1;
                        end
                        CLS_LINE: begin
                            n_line_ready = 1'b1;
                        end
                        CLS_BAD_FRAME: begin
                            if (r_nak_ok) begin
                                emit_req          = 1'b1;
                                item.action       = ACT_SEND_NAK;
                                item.ack_number   = ack_o;
                                item.ack_tmr_stop = 1'b1;
                                n_line_ready      = 1'b0;
                            end
                        end
                        CLS_DATA_FRAME: begin
                            if (r_evt.seq == r_exp) begin
                                emit_req              = 1'b1;
                                item.action           = ACT_DELIVER;
                                item.delivered_length = r_evt.dlen;
                                item.ack_tmr_start    = 1'b1;
                                n_nak_ok              = 1'b1;
                                n_exp                 = r_exp + 1'b1;
                            end else if (r_nak_ok) begin
                                emit_req          = 1'b1;
                                item.action       = ACT_SEND_NAK;
                                item.ack_number   = ack_o;
                                item.ack_tmr_stop = 1'b1;
                                n_nak_ok          = 1'b0;
                                n_line_ready      = 1'b0;
                            end
                        end
                        CLS_RESEND: begin
                            n_nts        = r_oldest;
                            n_rem        = r_outstanding;
                            n_line_ready = 1'b0;
                        end
                        CLS_ACK_TIMEOUT: begin
                            emit_req          = 1'b1;
                            item.action       = ACT_SEND_ACK;
                            item.ack_number   = ack_o;
                            item.ack_tmr_stop = 1'b1;
                            n_line_ready      = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ACKS: begin
                // one acknowledged frame per cycle while the output is not stalled
                if (out_free && in_win) begin
                    emit_req    = 1'b1;
                    item.action = ACT_STOP_TMR;
                    item.slot   = r_oldest;
                    if (r_outstanding != '0) n_outstanding = r_outstanding - 1'b1;
                    n_oldest    = r_oldest + 1'b1;
                end
            end
            ST_NAK_STOP: begin
                if (out_free) begin
                    emit_req     = 1'b1;
                    item.action  = ACT_STOP_TMR;
                    item.slot    = r_oldest + 1'b1;
                    n_nts        = r_oldest;
                    n_rem        = r_outstanding;
                    n_line_ready = 1'b0;
                end
            end
            ST_RESEND: begin
                // go back: resend every buffered frame from the oldest
                if (out_free && (r_rem != '0)) begin
                    emit_req          = 1'b1;
                    item.action       = ACT_SEND_DATA;
                    item.slot         = r_nts;
                    item.ack_number   = ack_o;
                    item.ack_tmr_stop = 1'b1;
                    n_nts             = r_nts + 1'b1;
                    n_rem             = r_rem - 1'b1;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    emit_req            = 1'b1;
                    item.action         = ACT_STATUS;
                    item.network_enable = (32'(r_outstanding) < WinLimit) && r_line_ready;
                    item.last           = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // command budget: the status always goes out, others only within the budget
    always_comb begin
        do_emit   = emit_req && (item.last || (r_emitted < MAX_CMDS));
        n_emitted = r_emitted;
        if (o_pop) begin
            n_emitted = '0;
        end else if (do_emit && !item.last) begin
            n_emitted = r_emitted + 1'b1;
        end
        n_out = r_out;
        if (do_emit) begin
            n_out_valid = 1'b1;
            n_out       = item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_nts         <= '0;
            r_oldest      <= '0;
            r_exp         <= '0;
            r_outstanding <= '0;
            r_line_ready  <= 1'b0;
            r_nak_ok      <= 1'b1;
            r_rem         <= '0;
            r_emitted     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_nts         <= n_nts;
            r_oldest      <= n_oldest;
            r_exp         <= n_exp;
            r_outstanding <= n_outstanding;
            r_line_ready  <= n_line_ready;
            r_nak_ok      <= n_nak_ok;
            r_rem         <= n_rem;
            r_emitted     <= n_emitted;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_evt <= n_evt;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_item      = r_out;

    `GLC_ASSERT_HOLD(a_budget, i_clk, i_rst_n, r_emitted <= MAX_CMDS)
    `GLC_ASSERT_IMPL(a_last_is_status, i_clk, i_rst_n, r_out_valid, (r_out.action == ACT_STATUS) == r_out.last)
    `GLC_ASSERT_NEXT(a_status_out, i_clk, i_rst_n, (r_state == ST_STATUS) && out_free, r_out_valid && r_out.last && (r_state == ST_IDLE))
    `GLC_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE)

endmodule

FILE: rtl/core/go_back_n_link_controller_unit.sv
// Go-back-N link controller with NAK over a 4-bit sequence space.
// Input channel (i_in_valid / o_in_stall): one link event per request, taken
// at an edge with valid high and stall low: packet ready, line ready, frame
// received (crc verdict, kind, sequence, ack, length), data or ack timeout.
// Output channel (o_out_valid / i_out_stall): an ordered run of commands per
// event (send data, send ack, send nak, deliver, stop data timer), closed by
// a status request with o_last high that carries o_network_enable.
// At most sixteen commands precede the status; later ones are dropped while
// the link state still advances.
// The first command shows once the event has passed the queue register, the
// idle and head states and the output register, and also the ack, nak-stop
// or resend states it passes first when it opens with a stop-timer or resend
// command; within the ack and resend loops one command per cycle follows while
// the receiver does not stall. The sequencer handles one event at a time.
// A two-entry event queue keeps taking events while the sequencer works.
// When the receiver stalls, the output register holds its command and the
// sequencer waits; once the queue is full o_in_stall rises.
// Reset (i_rst_n low, synchronous) empties queue and output and sets the
// window pointers, counts and line-ready flag to zero and allows a NAK.
`timescale 1ns / 1ps

module go_back_n_link_controller_unit
    import glc_pkg::*;
#(
    parameter int WINDOW_SIZE = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_operation,
    input  logic             i_frame_good,
    input  logic [1:0]       i_frame_kind,
    input  logic [SEQ_W-1:0] i_frame_seq,
    input  logic [SEQ_W-1:0] i_frame_ack,
    input  logic [LEN_W-1:0] i_frame_length,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_action,
    output logic [SEQ_W-1:0] o_slot,
    output logic             o_load_slot,
    output logic [SEQ_W-1:0] o_ack_number,
    output logic [LEN_W-1:0] o_delivered_length,
    output logic             o_ack_tmr_start,
    output logic             o_ack_tmr_stop,
    output logic             o_network_enable,
    output logic             o_last
);

    t_queue_head head;
    logic        pop;
    t_item       item;

    // event intake and classification
    glc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_frame_good   (i_frame_good),
        .i_frame_kind   (i_frame_kind),
        .i_frame_seq    (i_frame_seq),
        .i_frame_ack    (i_frame_ack),
        .i_frame_length (i_frame_length),
        .o_head         (head),
        .i_pop          (pop)
    );

    // command sequencer
    glc_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_item      (item)
    );

    // result fields
    assign o_action           = item.action;
    assign o_slot             = item.slot;
    assign o_load_slot        = item.load_slot;
    assign o_ack_number       = item.ack_number;
    assign o_delivered_length = item.delivered_length;
    assign o_ack_tmr_start    = item.ack_tmr_start;
    assign o_ack_tmr_stop     = item.ack_tmr_stop;
    assign o_network_enable   = item.network_enable;
    assign o_last             = item.last;

endmodule
